>>> hdl/nli_pkg.sv
// Package for the large-ideal extractor.
// Holds word types, queue sizing and register index codes.
// No dependencies.
package nli_pkg;

	// register indexes on the configuration port
	localparam logic [1:0] REG_FILTMIN_RAT = 2'd0;
	localparam logic [1:0] REG_FILTMIN_ALG = 2'd1;
	localparam logic [1:0] REG_SMALL_LIM   = 2'd2;

	// command queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	localparam logic [31:0] SIGN_ROOT = 32'hffffffff;
	localparam logic [30:0] SIGN_HALF = 31'h7fffffff;

	typedef struct packed {
		logic signed [63:0] rel_a;
		logic [31:0]        rel_b;
		logic [31:0]        factor_value;
		logic               side;
		logic               first_of_relation;
		logic               last_of_relation;
	} nli_in_t;

	typedef struct packed {
		logic        has_ideal;
		logic [31:0] ideal_root;
		logic [30:0] ideal_prime_half;
		logic        ideal_side;
		logic        relation_done;
		logic [8:0]  ideal_tally;
		logic [15:0] small_ideal_count;
		logic        overflow;
	} nli_out_t;

	typedef struct packed {
		logic [31:0] filtmin_rational;
		logic [31:0] filtmin_algebraic;
		logic [31:0] small_prime_limit;
	} nli_cfg_t;

	// classified word handed from front to back
	typedef struct packed {
		nli_out_t           res;
		logic               need_alg;
		logic signed [63:0] rel_a;
		logic [31:0]        rel_b;
		logic [31:0]        prime;
	} nli_cmd_t;

endpackage

>>> hdl/nli_front.sv
// Front end: classifies each accepted word and keeps the per-relation counts.
// Depends on nli_pkg.
module nli_front #(
	parameter int MAX_IDEALS = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_accept,
	input  nli_pkg::nli_in_t  in_word,
	input  nli_pkg::nli_cfg_t cfg,
	output logic              enq,
	output nli_pkg::nli_cmd_t cmd
);
	localparam int IW = $clog2(MAX_IDEALS + 1);
	localparam logic [IW-1:0] MAXI = IW'(MAX_IDEALS);

	logic [31:0]   free_prime_q;
	logic [IW-1:0] ideals_q;
	logic [15:0]   small_q;
	logic          ovf_q;

	logic [IW-1:0] ideals_c, ideals_n;
	logic [15:0]   small_c, small_n;
	logic          ovf_c, ovf_n;
	logic [31:0]   free_n, p, root;
	logic [30:0]   half;
	logic          emit, want, count, iside, need_alg;
	logic [IW+8:0] ideals_ext;

	// classification and count update
	always_comb begin
		ideals_c = in_word.first_of_relation ? '0 : ideals_q;
		small_c  = in_word.first_of_relation ? '0 : small_q;
		ovf_c    = in_word.first_of_relation ? 1'b0 : ovf_q;
		ideals_n = ideals_c;
		ovf_n    = ovf_c;
		free_n   = free_prime_q;
		emit     = 1'b0;
		want     = 1'b0;
		count    = 1'b0;
		iside    = 1'b0;
		need_alg = 1'b0;
		root     = '0;
		p        = in_word.factor_value;
		half     = '0;
		if (in_word.rel_b == '0) begin
			if (in_word.first_of_relation) begin
				free_n = in_word.factor_value;
				if (p > cfg.filtmin_rational) begin
					emit = 1'b1;
					root = p;
				end else if (p > cfg.small_prime_limit) begin
					count = 1'b1;
				end
			end else begin
				p = free_prime_q;
				iside = 1'b1;
				if (p > cfg.filtmin_algebraic) begin
					emit = 1'b1;
					root = in_word.factor_value;
				end else if (p > cfg.small_prime_limit) begin
					count = 1'b1;
				end
			end
			half = 31'((p - 32'd1) >> 1);
			if (emit && ideals_c < MAXI) begin
				ideals_n = ideals_c + IW'(1);
			end
		end else if (!ovf_c) begin
			half = 31'((p - 32'd1) >> 1);
			if (!in_word.side) begin
				if (p == '0 && cfg.filtmin_rational == '0) begin
					want = 1'b1;
					root = nli_pkg::SIGN_ROOT;
					half = nli_pkg::SIGN_HALF;
				end else if (p > cfg.filtmin_rational) begin
					want = 1'b1;
					root = p;
				end else if (p > cfg.small_prime_limit) begin
					count = 1'b1;
				end
			end else begin
				iside = 1'b1;
				if (p > cfg.filtmin_algebraic) begin
					want = 1'b1;
					need_alg = 1'b1;
				end else if (p > cfg.small_prime_limit) begin
					count = 1'b1;
				end
			end
			if (want) begin
				if (ideals_c >= MAXI) begin
					ovf_n = 1'b1;
				end else begin
					emit = 1'b1;
					ideals_n = ideals_c + IW'(1);
				end
			end
		end
		small_n = (count && small_c != 16'hffff) ? small_c + 16'd1 : small_c;
	end

	assign ideals_ext = {9'd0, ideals_n};
	assign enq = in_accept && (emit || in_word.last_of_relation);

	// command word; ideal fields are zero when nothing is emitted
	always_comb begin
		cmd.res.has_ideal         = emit;
		cmd.res.ideal_root        = emit ? root : '0;
		cmd.res.ideal_prime_half  = emit ? half : '0;
		cmd.res.ideal_side        = emit ? iside : 1'b0;
		cmd.res.relation_done     = in_word.last_of_relation;
		cmd.res.ideal_tally       = ideals_ext[8:0];
		cmd.res.small_ideal_count = small_n;
		cmd.res.overflow          = ovf_n;
		cmd.need_alg              = emit && need_alg;
		cmd.rel_a                 = in_word.rel_a;
		cmd.rel_b                 = in_word.rel_b;
		cmd.prime                 = p;
	end

	// relation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_prime_q <= '0;
			ideals_q     <= '0;
			small_q      <= '0;
			ovf_q        <= 1'b0;
		end else if (in_accept) begin
			free_prime_q <= free_n;
			ideals_q     <= ideals_n;
			small_q      <= small_n;
			ovf_q        <= ovf_n;
		end
	end

endmodule

>>> hdl/nli_fifo.sv
// Short command queue between front and back.
// Depends on nli_pkg.
module nli_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  nli_pkg::nli_cmd_t wdata,
	input  logic              rd,
	output nli_pkg::nli_cmd_t rdata,
	output logic              full,
	output logic              nempty
);
	nli_pkg::nli_cmd_t        mem_q [nli_pkg::QDEPTH];
	logic [nli_pkg::QAW-1:0]  wp_q, rp_q;
	logic [nli_pkg::QAW:0]    cnt_q;

	assign full   = cnt_q == (nli_pkg::QAW+1)'(nli_pkg::QDEPTH);
	assign nempty = cnt_q != '0;
	assign rdata  = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	// pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (nli_pkg::QAW+1)'(wr) - (nli_pkg::QAW+1)'(rd);
		end
	end

endmodule

>>> hdl/nli_back.sv
// Back end: computes the algebraic root a*b^-1 mod p with bit-serial units, or p when b has no inverse.
// Depends on nli_pkg.
module nli_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  nli_pkg::nli_cmd_t cmd,
	output logic              cmd_pop,
	output logic              res_valid,
	output nli_pkg::nli_out_t res,
	input  logic              res_ready
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RED  = 3'd1;
	localparam logic [2:0] ST_PREP = 3'd2;
	localparam logic [2:0] ST_ECHK = 3'd3;
	localparam logic [2:0] ST_EDIV = 3'd4;
	localparam logic [2:0] ST_MUL  = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	logic [2:0]         state_q;
	nli_pkg::nli_out_t  res_q;
	logic [31:0]        p_q, ra_q, rb_q, bsh_q, am_q;
	logic [63:0]        amag_q;
	logic               neg_q;
	logic [5:0]         cnt_q;
	logic [31:0]        r0_q, r1_q, drem_q, dnum_q, mul_q, inv_q;
	logic signed [34:0] s0_q, s1_q, dacc_q;

	logic [32:0]        ta, tb, td, tm;
	logic [31:0]        ra_n, rb_n, drem_n, mul_n;
	logic signed [34:0] dacc_n, inv_full;
	logic [32:0]        tm2;

	// restoring reduction steps for a and b
	always_comb begin
		ta   = {ra_q, amag_q[63]};
		ra_n = (ta >= {1'b0, p_q}) ? 32'(ta - {1'b0, p_q}) : ta[31:0];
		tb   = {rb_q, bsh_q[31]};
		rb_n = (tb >= {1'b0, p_q}) ? 32'(tb - {1'b0, p_q}) : tb[31:0];
	end

	// one quotient bit of r0 / r1, accumulating q * s1 alongside
	always_comb begin
		td = {drem_q, dnum_q[31]};
		if (td >= {1'b0, r1_q}) begin
			drem_n = 32'(td - {1'b0, r1_q});
			dacc_n = (dacc_q <<< 1) + s1_q;
		end else begin
			drem_n = td[31:0];
			dacc_n = dacc_q <<< 1;
		end
	end

	// one step of interleaved modular multiply am * inv
	always_comb begin
		tm  = {mul_q, 1'b0};
		if (tm >= {1'b0, p_q}) tm = tm - {1'b0, p_q};
		tm2 = inv_q[31] ? tm + {1'b0, am_q} : tm;
		mul_n = (tm2 >= {1'b0, p_q}) ? 32'(tm2 - {1'b0, p_q}) : tm2[31:0];
	end

	assign inv_full  = (s0_q < 0) ? s0_q + 35'(p_q) : s0_q;
	assign cmd_pop   = (state_q == ST_IDLE) && cmd_valid;
	assign res_valid = state_q == ST_DONE;
	assign res       = res_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (cmd_valid) state_q <= cmd.need_alg ? ST_RED : ST_DONE;
				end
				ST_RED: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) state_q <= ST_PREP;
				end
				ST_PREP: state_q <= (rb_q == '0) ? ST_DONE : ST_ECHK;
				ST_ECHK: begin
					cnt_q <= '0;
					if (r1_q != '0) state_q <= ST_EDIV;
					else if (r0_q != 32'd1) state_q <= ST_DONE;
					else state_q <= ST_MUL;
				end
				ST_EDIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) state_q <= ST_ECHK;
				end
				ST_MUL: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) state_q <= ST_DONE;
				end
				ST_DONE: if (res_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				res_q  <= cmd.res;
				p_q    <= cmd.prime;
				neg_q  <= cmd.rel_a[63];
				amag_q <= cmd.rel_a[63] ? 64'(-cmd.rel_a) : cmd.rel_a;
				bsh_q  <= cmd.rel_b;
				ra_q   <= '0;
				rb_q   <= '0;
			end
			ST_RED: begin
				ra_q   <= ra_n;
				amag_q <= amag_q << 1;
				if (!cnt_q[5]) begin
					rb_q  <= rb_n;
					bsh_q <= bsh_q << 1;
				end
			end
			ST_PREP: begin
				am_q <= neg_q ? ((ra_q != '0) ? p_q - ra_q : '0) : ra_q;
				r0_q <= p_q;
				r1_q <= rb_q;
				s0_q <= '0;
				s1_q <= 35'sd1;
				if (rb_q == '0) res_q.ideal_root <= p_q;
			end
			ST_ECHK: begin
				drem_q <= '0;
				dnum_q <= r0_q;
				dacc_q <= '0;
				mul_q  <= '0;
				inv_q  <= inv_full[31:0];
				if (r1_q == '0 && r0_q != 32'd1) res_q.ideal_root <= p_q;
			end
			ST_EDIV: begin
				drem_q <= drem_n;
				dnum_q <= dnum_q << 1;
				dacc_q <= dacc_n;
				if (cnt_q == 6'd31) begin
					r0_q <= r1_q;
					r1_q <= drem_n;
					s0_q <= s1_q;
					s1_q <= s0_q - dacc_n;
				end
			end
			ST_MUL: begin
				mul_q <= mul_n;
				inv_q <= inv_q << 1;
				if (cnt_q == 6'd31) res_q.ideal_root <= mul_n;
			end
			default: ;
		endcase
	end

endmodule

>>> hdl/nfs_large_ideal_extractor.sv
// Top level of the large-ideal extractor: config registers, front, queue, back
// and the result register. Depends on nli_pkg, nli_front, nli_fifo, nli_back.
//
//  channel   handshake          payload
//  input     push / full        in_word  (nli_in_t)
//  result    empty / pop        out_word (nli_out_t)
//  config    psel/penable/...   paddr, pwdata, prdata
//
// The front takes a word every cycle while the four-deep queue has room.
// Words with a plain result pass straight from idle to done in the back. An
// algebraic ideal needs the reduction of a and b, the Euclid steps of the
// inverse, the modular multiply and the sequencing, all in the back unit.
// Reset clears counts, registers and queues; either side may stall freely.
module nfs_large_ideal_extractor #(
	parameter int MAX_IDEALS = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  nli_pkg::nli_in_t  in_word,
	output logic              empty,
	input  logic              pop,
	output nli_pkg::nli_out_t out_word,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	nli_pkg::nli_cfg_t cfg_q;
	nli_pkg::nli_cmd_t enq_cmd, deq_cmd;
	nli_pkg::nli_out_t back_res, out_q;
	logic              enq, q_full, q_nempty, deq, back_valid, back_ready, out_valid_q;
	logic              in_accept;

	assign pready    = 1'b1;
	assign full      = q_full;
	assign in_accept = push && !q_full;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				nli_pkg::REG_FILTMIN_RAT: cfg_q.filtmin_rational  <= pwdata;
				nli_pkg::REG_FILTMIN_ALG: cfg_q.filtmin_algebraic <= pwdata;
				nli_pkg::REG_SMALL_LIM:   cfg_q.small_prime_limit <= pwdata;
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (paddr[3:2])
			nli_pkg::REG_FILTMIN_RAT: prdata = cfg_q.filtmin_rational;
			nli_pkg::REG_FILTMIN_ALG: prdata = cfg_q.filtmin_algebraic;
			nli_pkg::REG_SMALL_LIM:   prdata = cfg_q.small_prime_limit;
			default:                  prdata = '0;
		endcase
	end

	nli_front #(.MAX_IDEALS(MAX_IDEALS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_accept(in_accept), .in_word(in_word),
		.cfg(cfg_q), .enq(enq), .cmd(enq_cmd)
	);

	nli_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .wr(enq), .wdata(enq_cmd), .rd(deq),
		.rdata(deq_cmd), .full(q_full), .nempty(q_nempty)
	);

	nli_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(q_nempty), .cmd(deq_cmd),
		.cmd_pop(deq), .res_valid(back_valid), .res(back_res), .res_ready(back_ready)
	);

	// result register
	assign back_ready = !out_valid_q || pop;
	assign empty      = !out_valid_q;
	assign out_word   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (back_ready) begin
			out_valid_q <= back_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (back_ready && back_valid) out_q <= back_res;
	end

	a_no_enq_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !enq) else $error("queue overrun");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_word)))
		else $error("result word lost");

	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !out_word.has_ideal) |->
		(out_word.ideal_root == '0 && out_word.ideal_side == 1'b0))
		else $error("fields set without ideal");

endmodule
